[sv/tgt_pkg.sv]
package tgt_pkg;

    localparam int MAX_GAINS   = 8;
    localparam int IDX_W       = 3;
    localparam int WORD_W      = 32;
    localparam int SUM_W       = 35;
    localparam int COUNT_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    // opcodes of an input request
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // configuration register indexes
    localparam logic CFG_STOP_THRESHOLD = 1'b0;
    localparam logic CFG_GAINS_IN_USE   = 1'b1;

    localparam logic [WORD_W-1:0]  THRESHOLD_RESET = 32'd13107;
    localparam logic [COUNT_W-1:0] GAINS_RESET     = 4'd3;

    typedef struct packed {
        logic              is_report;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] step;
        logic [WORD_W-1:0] err;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0]  stop_threshold;
        logic [COUNT_W-1:0] gains_in_use;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]  gain_index;
        logic [WORD_W-1:0] gain_value;
        logic              converged;
        logic              last;
    } t_result;

endpackage

[sv/tgt_front.sv]
module tgt_front
    import tgt_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic [WORD_W-1:0]        i_start_value,
    input  logic [WORD_W-1:0]        i_start_step,
    input  logic [WORD_W-1:0]        i_error_score,
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd,
    input  logic                     i_cmd_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_fifo [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    logic accept, keep, push, pop;
    t_cmd cmd_in;

    assign o_in_stall = (r_count == CNT_W'(QUEUE_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    // drop loads aimed past the store
    assign keep       = (i_opcode == OP_REPORT) || (int'(i_entry_index) < MAX_GAINS);
    assign push       = accept && keep;
    assign pop        = i_cmd_pop && (r_count != '0);

    assign cmd_in.is_report = (i_opcode == OP_REPORT);
    assign cmd_in.index     = i_entry_index;
    assign cmd_in.value     = i_start_value;
    assign cmd_in.step      = i_start_step;
    assign cmd_in.err       = i_error_score;

    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_fifo[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

[sv/tgt_back.sv]
module tgt_back
    import tgt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_result o_out
);

    localparam int K_W  = FRAC_BITS + 1;
    localparam int PW   = WORD_W + K_W;
    localparam longint unsigned K105_L = ((64'd105 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned K110_L = ((64'd110 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam longint unsigned K095_L = ((64'd95 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [K_W-1:0] K_105 = K105_L[K_W-1:0];
    localparam logic [K_W-1:0] K_110 = K110_L[K_W-1:0];
    localparam logic [K_W-1:0] K_095 = K095_L[K_W-1:0];
    localparam logic [PW-1:0]  HALF  = PW'(1) << (FRAC_BITS - 1);

    localparam logic [WORD_W-1:0] S_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] S_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADV   = 3'd3;
    localparam logic [2:0] ST_BUMP  = 3'd4;

    function automatic logic [WORD_W-1:0] sat33(input logic [WORD_W:0] v);
        if (v[WORD_W] != v[WORD_W-1]) begin
            return v[WORD_W] ? S_MIN : S_MAX;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] sat34(input logic [WORD_W+1:0] v);
        if ((v[WORD_W+1] != v[WORD_W]) || (v[WORD_W] != v[WORD_W-1])) begin
            return v[WORD_W+1] ? S_MIN : S_MAX;
        end
        return v[WORD_W-1:0];
    endfunction

    // gain and step stores
    logic [WORD_W-1:0] gain_mem [MAX_GAINS];
    logic [WORD_W-1:0] step_mem [MAX_GAINS];
    logic [WORD_W-1:0] r_gain_q, r_step_q;

    logic [2:0]        r_state,     n_state;
    logic [IDX_W-1:0]  r_active,    n_active;
    logic              r_have_best, n_have_best;
    logic              r_retry,     n_retry;
    logic [WORD_W-1:0] r_best,      n_best;
    logic [SUM_W-1:0]  r_sum,       n_sum;
    logic [WORD_W-1:0] r_err;
    logic [PW-1:0]     r_prod;
    logic              r_neg;
    logic              r_out_valid, n_out_valid;
    t_result           r_out;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              gain_we, step_we;
    logic [IDX_W-1:0]  gain_wa, step_wa;
    logic [WORD_W-1:0] gain_wd, step_wd;
    logic              emit, out_free, pop, mul_en;
    t_result           emit_res;
    logic [K_W-1:0]    kmul;

    logic [WORD_W-1:0]  step_mag;
    logic [WORD_W:0]    gain_up;
    logic [WORD_W+1:0]  gain_dn;
    logic [PW-1:0]      rsum;
    logic [WORD_W:0]    rp;
    logic [WORD_W-1:0]  new_step;
    logic               converged;
    logic [COUNT_W-1:0] in_use;
    logic [COUNT_W-1:0] nx_wide;
    logic [IDX_W-1:0]   nx;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_cmd_pop   = pop;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign step_mag = r_step_q[WORD_W-1] ? (~r_step_q + 1'b1) : r_step_q;
    assign gain_up  = {r_gain_q[WORD_W-1], r_gain_q} + {r_step_q[WORD_W-1], r_step_q};
    assign gain_dn  = {{2{r_gain_q[WORD_W-1]}}, r_gain_q}
                    - {r_step_q[WORD_W-1], r_step_q, 1'b0};

    // round to nearest on the magnitude, then saturate with the sign
    assign rsum = r_prod + HALF;
    assign rp   = rsum[FRAC_BITS +: (WORD_W + 1)];
    always_comb begin
        if (r_neg) begin
            new_step = (rp > {1'b0, S_MIN}) ? S_MIN : (~rp[WORD_W-1:0] + 1'b1);
        end else begin
            new_step = (rp > {1'b0, S_MAX}) ? S_MAX : rp[WORD_W-1:0];
        end
    end

    assign converged = $signed(r_sum) <= $signed({{(SUM_W-WORD_W){1'b0}}, i_cfg.stop_threshold});

    always_comb begin
        if (i_cfg.gains_in_use == '0) begin
            in_use = COUNT_W'(1);
        end else if (int'(i_cfg.gains_in_use) > MAX_GAINS) begin
            in_use = COUNT_W'(MAX_GAINS);
        end else begin
            in_use = i_cfg.gains_in_use;
        end
    end
    assign nx_wide = COUNT_W'(r_active) + 1'b1;
    assign nx      = (nx_wide >= in_use) ? '0 : nx_wide[IDX_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_have_best = r_have_best;
        n_retry     = r_retry;
        n_best      = r_best;
        n_sum       = r_sum;
        rd_en       = 1'b0;
        rd_addr     = r_active;
        gain_we     = 1'b0;
        gain_wa     = r_active;
        gain_wd     = gain_up[WORD_W-1:0];
        step_we     = 1'b0;
        step_wa     = r_active;
        step_wd     = new_step;
        emit        = 1'b0;
        emit_res    = '0;
        mul_en      = 1'b0;
        kmul        = K_110;

        unique case (r_state)
            ST_IDLE: begin
                if (pop) begin
                    if (!i_cmd.is_report) begin
                        gain_we = 1'b1;
                        gain_wa = i_cmd.index;
                        gain_wd = i_cmd.value;
                        step_we = 1'b1;
                        step_wa = i_cmd.index;
                        step_wd = i_cmd.step;
                        if (i_cmd.index == '0) begin
                            n_sum       = SUM_W'($signed(i_cmd.step));
                            n_have_best = 1'b0;
                            n_retry     = 1'b0;
                        end else begin
                            n_sum = r_sum + SUM_W'($signed(i_cmd.step));
                        end
                    end else if (!r_have_best) begin
                        // first report: take it as the best and bump gain 0
                        n_best      = i_cmd.err;
                        n_have_best = 1'b1;
                        n_active    = '0;
                        rd_en       = 1'b1;
                        rd_addr     = '0;
                        n_state     = ST_BUMP;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_active;
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                priority if (converged) begin
                    emit_res = '{gain_index: r_active, gain_value: r_gain_q,
                                 converged: 1'b1, last: 1'b1};
                    emit = 1'b1;
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (r_err < r_best) begin
                    n_best  = r_err;
                    kmul    = r_retry ? K_105 : K_110;
                    mul_en  = 1'b1;
                    n_state = ST_ROUND;
                end else if (r_retry) begin
                    emit_res = '{gain_index: r_active, gain_value: sat33(gain_up),
                                 converged: 1'b0, last: 1'b0};
                    emit = 1'b1;
                    if (out_free) begin
                        gain_we = 1'b1;
                        gain_wd = sat33(gain_up);
                        kmul    = K_095;
                        mul_en  = 1'b1;
                        n_state = ST_ROUND;
                    end
                end else begin
                    emit_res = '{gain_index: r_active, gain_value: sat34(gain_dn),
                                 converged: 1'b0, last: 1'b1};
                    emit = 1'b1;
                    if (out_free) begin
                        gain_we = 1'b1;
                        gain_wd = sat34(gain_dn);
                        n_retry = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_ROUND: begin
                step_we = 1'b1;
                n_sum   = r_sum + SUM_W'($signed(new_step)) - SUM_W'($signed(r_step_q));
                n_retry = 1'b0;
                n_state = ST_ADV;
            end
            ST_ADV: begin
                n_active = nx;
                rd_en    = 1'b1;
                rd_addr  = nx;
                n_state  = ST_BUMP;
            end
            ST_BUMP: begin
                emit_res = '{gain_index: r_active, gain_value: sat33(gain_up),
                             converged: 1'b0, last: 1'b1};
                emit = 1'b1;
                if (out_free) begin
                    gain_we = 1'b1;
                    gain_wd = sat33(gain_up);
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (out_free) begin
            n_out_valid = emit;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_active    <= '0;
            r_have_best <= 1'b0;
            r_retry     <= 1'b0;
            r_best      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_have_best <= n_have_best;
            r_retry     <= n_retry;
            r_best      <= n_best;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (gain_we) begin
            gain_mem[gain_wa] <= gain_wd;
        end
        if (step_we) begin
            step_mem[step_wa] <= step_wd;
        end
        if (rd_en) begin
            r_gain_q <= gain_mem[rd_addr];
            r_step_q <= step_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_err <= i_cmd.err;
        end
        if (mul_en) begin
            r_prod <= PW'(step_mag) * PW'(kmul);
            r_neg  <= r_step_q[WORD_W-1];
        end
        if (emit && out_free) begin
            r_out <= emit_res;
        end
    end

endmodule

[sv/twiddle_gain_tuner.sv]
// Coordinate-descent gain tuner for up to eight Q16.16 gains.
// Input channel (i_in_valid / o_in_stall): a load request (opcode 0) writes
// one entry's start value and step; loading entry 0 restarts the search.
// A report request (opcode 1) hands in the error of the last trial and
// yields one or two results.
// Output channel (o_out_valid / i_out_stall): each result names a gain and
// its new value, or flags convergence; o_last marks the final result of a
// report.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 is the
// stop threshold, index 1 the number of gains in use; write while idle.
// A request enters a two-entry queue at its accepting edge; the sequencer
// can take it from the next cycle on. A load is written to the stores as
// it leaves the queue. A report that converges, is the first report or is
// a first miss needs a store read followed by its emitting step; an
// improvement or a second miss runs read, step multiply, round, advance,
// bump. The first result is registered after the read and, on an
// improvement, after the multiply, round and advance steps as well.
// Reset empties the queue and output register and restarts the search;
// stored gains and steps must be reloaded. While the receiver stalls, the
// result holds, the sequencer waits and the queue fills, then stalls input.
module twiddle_gain_tuner
    import tgt_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_opcode,
    input  logic [IDX_W-1:0]         i_entry_index,
    input  logic signed [WORD_W-1:0] i_start_value,
    input  logic signed [WORD_W-1:0] i_start_step,
    input  logic [WORD_W-1:0]        i_error_score,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [IDX_W-1:0]         o_gain_index,
    output logic signed [WORD_W-1:0] o_gain_value,
    output logic                     o_converged,
    output logic                     o_last,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [WORD_W-1:0]        i_cfg_data
);

    t_cfg    r_cfg;
    logic    cmd_valid;
    t_cmd    cmd;
    logic    cmd_pop;
    t_result out_res;

    // config registers: always take a write request
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_threshold <= THRESHOLD_RESET;
            r_cfg.gains_in_use   <= GAINS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_STOP_THRESHOLD: r_cfg.stop_threshold <= i_cfg_data;
                CFG_GAINS_IN_USE:   r_cfg.gains_in_use   <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accept, classify, queue
    tgt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_entry_index (i_entry_index),
        .i_start_value (i_start_value),
        .i_start_step  (i_start_step),
        .i_error_score (i_error_score),
        .o_cmd_valid   (cmd_valid),
        .o_cmd         (cmd),
        .i_cmd_pop     (cmd_pop)
    );

    // back: run the search step and register the results
    tgt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (out_res)
    );

    assign o_gain_index = out_res.gain_index;
    assign o_gain_value = out_res.gain_value;
    assign o_converged  = out_res.converged;
    assign o_last       = out_res.last;

endmodule

[sv/tgt_checker.sv]
module tgt_checker
    import tgt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [IDX_W-1:0]  o_gain_index,
    input logic [WORD_W-1:0] o_gain_value,
    input logic              o_converged,
    input logic              o_last,
    input logic              o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_gain_index)
            && $stable(o_gain_value) && $stable(o_converged) && $stable(o_last))
        else $error("stalled result changed");

    // a converged result is always the only one of its report
    a_conv_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_converged |-> o_last)
        else $error("converged result not marked last");

    // reset leaves no result pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear channels");

    // the config port never blocks
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_cfg_ready)
        else $error("config port not ready");

endmodule

bind twiddle_gain_tuner tgt_checker u_tgt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_gain_index (o_gain_index),
    .o_gain_value (o_gain_value),
    .o_converged  (o_converged),
    .o_last       (o_last),
    .o_cfg_ready  (o_cfg_ready)
);
